FILE: rtl/core/cshl_pkg.sv
// shared types and constants for the c source highlight lexer
`timescale 1ns / 1ps
`default_nettype none

package cshl_pkg;

   // byte offsets saturate at this width
   localparam int POSITION_BITS = 16;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // result queue depth
   localparam int FIFO_DEPTH = 4;

   // token kinds as seen on the result channel
   typedef enum logic [2:0] {
      KIND_TEXT   = 3'd0,
      KIND_LINE   = 3'd1,
      KIND_BLOCK  = 3'd2,
      KIND_PRE    = 3'd3,
      KIND_STRING = 3'd4,
      KIND_NUMBER = 3'd5,
      KIND_CHAR   = 3'd6
   } kind_type;

   // one result word
   typedef struct packed {
      kind_type                 token_kind;
      logic [POSITION_BITS-1:0] token_offset;
      logic [POSITION_BITS-1:0] token_length;
      logic                     final_token;
      logic                     last_in_run;
   } token_type;

   // tokens pushed into the result queue by one accepted byte
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

endpackage

`default_nettype wire

FILE: rtl/core/cshl_req_if.sv
// input channel: one source byte per word
`timescale 1ns / 1ps
`default_nettype none

interface cshl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_of_source;

   modport source (output valid, output source_byte, output end_of_source, input ready);
   modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cshl_rsp_if.sv
// result channel: one token per word
`timescale 1ns / 1ps
`default_nettype none

interface cshl_rsp_if;
   logic                               valid;
   logic                               ready;
   cshl_pkg::kind_type                 token_kind;
   logic [cshl_pkg::POSITION_BITS-1:0] token_offset;
   logic [cshl_pkg::POSITION_BITS-1:0] token_length;
   logic                               final_token;
   logic                               last_in_run;

   modport source (output valid, output token_kind, output token_offset, output token_length,
                   output final_token, output last_in_run, input ready);
   modport sink (input valid, input token_kind, input token_offset, input token_length,
                 input final_token, input last_in_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cshl_lexer.sv
// lexer state machine: mode update and token formation for one byte
`timescale 1ns / 1ps
`default_nettype none

module cshl_lexer (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         source_byte,
   input  logic               end_of_source,
   output cshl_pkg::push_type push
);
   import cshl_pkg::*;

   typedef enum logic [3:0] {
      MODE_NORMAL = 4'd0,
      MODE_SLASH  = 4'd1,
      MODE_LINE   = 4'd2,
      MODE_BLOCK  = 4'd3,
      MODE_STAR   = 4'd4,
      MODE_PRE    = 4'd5,
      MODE_STRING = 4'd6,
      MODE_NUMBER = 4'd7,
      MODE_CHAR   = 4'd8
   } mode_type;

   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   // mode entered from plain text on this byte
   function automatic mode_type open_mode(input logic [7:0] c);
      mode_type m;
      m = MODE_NORMAL;
      if (c == CHAR_SLASH) m = MODE_SLASH;
      else if (c == CHAR_HASH) m = MODE_PRE;
      else if (c == CHAR_DQUOTE) m = MODE_STRING;
      else if (c inside {[8'h30:8'h39]}) m = MODE_NUMBER;
      else if (c == CHAR_SQUOTE) m = MODE_CHAR;
      return m;
   endfunction

   mode_type                 mode_ff, mode_in, mode_mid;
   logic                     skip_ff, skip_in, skip_mid;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] run_start_ff, run_start_in, rs_mid;
   logic [POSITION_BITS-1:0] next_pos, close_to;
   logic                     close_hit, close_ok, flush_ok, num_char;
   kind_type                 close_kind, flush_kind;
   token_type                close_tok, flush_tok;

   assign next_pos = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign num_char = (source_byte inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
                     || (source_byte == CHAR_DOT);

   // mode transition and the run that this byte closes
   always_comb begin
      mode_mid   = mode_ff;
      rs_mid     = run_start_ff;
      skip_mid   = 1'b0;
      close_hit  = 1'b0;
      close_kind = KIND_TEXT;
      close_to   = pos_ff;
      if (!skip_ff) begin
         case (mode_ff)
            MODE_SLASH: begin
               if (source_byte == CHAR_SLASH) begin
                  mode_mid = MODE_LINE;
               end else if (source_byte == CHAR_STAR) begin
                  mode_mid = MODE_STAR;
               end else begin
                  close_hit = 1'b1;
                  rs_mid    = pos_ff;
                  mode_mid  = open_mode(source_byte);
               end
            end
            MODE_LINE, MODE_PRE: begin
               if (source_byte == CHAR_NEWLINE) begin
                  close_hit  = 1'b1;
                  close_kind = (mode_ff == MODE_LINE) ? KIND_LINE : KIND_PRE;
                  close_to   = next_pos;
                  rs_mid     = next_pos;
                  mode_mid   = MODE_NORMAL;
               end
            end
            MODE_BLOCK: begin
               if (source_byte == CHAR_STAR) mode_mid = MODE_STAR;
            end
            MODE_STAR: begin
               if (source_byte == CHAR_SLASH) begin
                  close_hit  = 1'b1;
                  close_kind = KIND_BLOCK;
                  close_to   = next_pos;
                  rs_mid     = next_pos;
                  mode_mid   = MODE_NORMAL;
               end else if (source_byte != CHAR_STAR) begin
                  mode_mid = MODE_BLOCK;
               end
            end
            MODE_STRING, MODE_CHAR: begin
               if (source_byte == CHAR_BACKSLASH) begin
                  skip_mid = 1'b1;
               end else if ((mode_ff == MODE_STRING && source_byte == CHAR_DQUOTE) ||
                            (mode_ff == MODE_CHAR && source_byte == CHAR_SQUOTE)) begin
                  close_hit  = 1'b1;
                  close_kind = (mode_ff == MODE_STRING) ? KIND_STRING : KIND_CHAR;
                  close_to   = next_pos;
                  rs_mid     = next_pos;
                  mode_mid   = MODE_NORMAL;
               end
            end
            MODE_NUMBER: begin
               if (!num_char) begin
                  close_hit  = 1'b1;
                  close_kind = KIND_NUMBER;
                  rs_mid     = pos_ff;
                  mode_mid   = open_mode(source_byte);
               end
            end
            default: begin
               // plain text, and any code with no meaning
               mode_mid = open_mode(source_byte);
               if (mode_mid != MODE_NORMAL) begin
                  close_hit = 1'b1;
                  rs_mid    = pos_ff;
               end
            end
         endcase
      end
   end

   // kind of the run still open at end of source
   always_comb begin
      case (mode_mid)
         MODE_LINE:              flush_kind = KIND_LINE;
         MODE_BLOCK, MODE_STAR:  flush_kind = KIND_BLOCK;
         MODE_PRE:               flush_kind = KIND_PRE;
         MODE_STRING:            flush_kind = KIND_STRING;
         MODE_NUMBER:            flush_kind = KIND_NUMBER;
         MODE_CHAR:              flush_kind = KIND_CHAR;
         default:                flush_kind = KIND_TEXT;
      endcase
   end

   // empty tokens are dropped
   assign close_ok = close_hit && (close_to > run_start_ff);
   assign flush_ok = end_of_source && (next_pos > rs_mid);

   always_comb begin
      close_tok.token_kind   = close_kind;
      close_tok.token_offset = run_start_ff;
      close_tok.token_length = close_to - run_start_ff;
      close_tok.final_token  = 1'b0;
      close_tok.last_in_run  = !flush_ok;
      flush_tok.token_kind   = flush_kind;
      flush_tok.token_offset = rs_mid;
      flush_tok.token_length = next_pos - rs_mid;
      flush_tok.final_token  = 1'b1;
      flush_tok.last_in_run  = 1'b1;
   end

   // compact the tokens of this byte into queue slots
   always_comb begin
      push.tok0  = close_ok ? close_tok : flush_tok;
      push.tok1  = flush_tok;
      push.count = 2'd0;
      if (accept) begin
         push.count = {1'b0, close_ok} + {1'b0, flush_ok};
      end
   end

   // next state: end of source returns everything to reset values
   always_comb begin
      mode_in      = mode_ff;
      skip_in      = skip_ff;
      pos_in       = pos_ff;
      run_start_in = run_start_ff;
      if (accept) begin
         if (end_of_source) begin
            mode_in      = MODE_NORMAL;
            skip_in      = 1'b0;
            pos_in       = '0;
            run_start_in = '0;
         end else begin
            mode_in      = mode_mid;
            skip_in      = skip_mid;
            pos_in       = next_pos;
            run_start_in = rs_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         skip_ff      <= 1'b0;
         pos_ff       <= '0;
         run_start_ff <= '0;
      end else begin
         mode_ff      <= mode_in;
         skip_ff      <= skip_in;
         pos_ff       <= pos_in;
         run_start_ff <= run_start_in;
      end
   end

   // escape skip only lives inside a string or char literal
   a_skip_in_literal: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (mode_ff == MODE_STRING || mode_ff == MODE_CHAR))
      else $error("escape skip outside a literal");

   // end of source restarts offsets and mode
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_source |=> pos_ff == '0 && run_start_ff == '0 && mode_ff == MODE_NORMAL)
      else $error("state not cleared after end of source");

   // the open run never starts beyond the next byte offset
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      run_start_ff <= pos_ff)
      else $error("run start ahead of byte position");

endmodule

`default_nettype wire

FILE: rtl/core/cshl_tok_fifo.sv
// small result queue: takes up to two tokens a cycle, gives one
`timescale 1ns / 1ps
`default_nettype none

module cshl_tok_fifo (
   input  logic                clock,
   input  logic                reset,
   input  cshl_pkg::push_type  push,
   output logic                space,
   output logic                out_valid,
   input  logic                out_ready,
   output cshl_pkg::token_type out_tok
);
   import cshl_pkg::*;

   localparam int PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;
   localparam logic [CNT_BITS-1:0] ROOM_LIMIT = CNT_BITS'(FIFO_DEPTH - 2);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT  = CNT_BITS'(FIFO_DEPTH);

   token_type             entry_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_nx;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  pop;

   // room for the worst case of two tokens from one byte
   assign space     = (count_ff <= ROOM_LIMIT);
   assign out_valid = (count_ff != '0);
   assign out_tok   = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign wr_ptr_nx = wr_ptr_ff + 1'b1;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in  = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // token storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.tok0;
      if (push.count == 2'd2) entry_ff[wr_ptr_nx] <= push.tok1;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("result queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= ROOM_LIMIT)
      else $error("tokens pushed without room");

   a_push_width: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("more than two tokens from one byte");

endmodule

`default_nettype wire

FILE: rtl/core/c_source_highlight_lexer_unit.sv
// top level of the c source highlight lexer
`timescale 1ns / 1ps
`default_nettype none

// Lexes C source one byte per cycle: each accepted byte word updates the
// lexer mode registers, so a new byte is taken every cycle while the
// four-entry result queue has room for two tokens. A byte yields zero, one or
// two token words (a closed run, then the end-of-source flush); the result
// channel drains one token a cycle while it is ready, so throughput is one
// byte a cycle while bytes average at most one token, and the queue fill sets
// back-pressure otherwise. Offsets saturate at 2^16 - 1; after the byte marked
// end of source all offsets restart at zero.
module c_source_highlight_lexer_unit (
   input  logic        clock,
   input  logic        reset,
   cshl_req_if.sink    req_chan,
   cshl_rsp_if.source  rsp_chan
);
   import cshl_pkg::*;

   push_type  push;
   token_type out_tok;
   logic      space;
   logic      req_accept;

   assign req_chan.ready = space;
   assign req_accept     = req_chan.valid && space;

   // mode update and token formation
   cshl_lexer u_lexer (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .source_byte   (req_chan.source_byte),
      .end_of_source (req_chan.end_of_source),
      .push          (push)
   );

   // result queue
   cshl_tok_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_tok   (out_tok)
   );

   assign rsp_chan.token_kind   = out_tok.token_kind;
   assign rsp_chan.token_offset = out_tok.token_offset;
   assign rsp_chan.token_length = out_tok.token_length;
   assign rsp_chan.final_token  = out_tok.final_token;
   assign rsp_chan.last_in_run  = out_tok.last_in_run;

endmodule

`default_nettype wire

FILE: tb/sv/c_source_highlight_lexer_unit_tb.sv
// testbench for the c source highlight lexer: directed table, then random c-like sources
`timescale 1ns / 1ps

module c_source_highlight_lexer_unit_tb;
   import cshl_pkg::*;

   // lexer modes of the token predictor
   typedef enum logic [3:0] {
      MODE_NORMAL = 4'd0,
      MODE_SLASH  = 4'd1,
      MODE_LINE   = 4'd2,
      MODE_BLOCK  = 4'd3,
      MODE_STAR   = 4'd4,
      MODE_PRE    = 4'd5,
      MODE_STRING = 4'd6,
      MODE_NUMBER = 4'd7,
      MODE_CHAR   = 4'd8
   } lex_mode_type;

   // bytes with a meaning to the lexer
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;

   localparam int OP_COUNT = 23;
   localparam logic [8*OP_COUNT-1:0] OPERATOR_BYTES = "+-*/=;(){}[]<>,&|!~%^?:";

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 80;

   // directed stimulus row
   typedef struct {
      logic [7:0] b;
      logic       eos;
      bit         typed;
      int         n;
      token_type  tok;
   } dir_row_type;

   logic clock;
   logic reset;

   cshl_req_if req_bus ();
   cshl_rsp_if rsp_bus ();

   c_source_highlight_lexer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predictor state
   lex_mode_type lex_mode;
   bit           escape_pending;
   logic [15:0]  next_offset;
   logic [15:0]  run_offset;

   token_type   byte_tokens[$];
   token_type   pending_tokens[$];
   token_type   typed_tokens[$];
   bit          typed_row;
   dir_row_type dir_rows[$];
   logic [7:0]  src_q[$];

   int sender_idle_pct;
   int sink_idle_pct;
   int hold_request;
   int mismatch_count;
   int idle_cycles;
   int bytes_sent;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void lex_reset();
      lex_mode       = MODE_NORMAL;
      escape_pending = 1'b0;
      next_offset    = '0;
      run_offset     = '0;
   endfunction

   function automatic bit is_word_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // empty runs never make a token
   function automatic void emit_token(kind_type kind, logic [15:0] lo, logic [15:0] hi,
                                      logic fin);
      if (hi > lo)
         byte_tokens.push_back(token_type'{kind, lo, hi - lo, fin, 1'b0});
   endfunction

   function automatic void close_run(kind_type kind, logic [15:0] upto);
      emit_token(kind, run_offset, upto, 1'b0);
      run_offset = upto;
   endfunction

   // tokens caused by one source byte, left in byte_tokens
   function automatic void lex_byte(logic [7:0] c, logic eos);
      logic [15:0] here;
      logic [15:0] nxt;
      bit          again;
      kind_type    flush_kind;
      int          pass;
      byte_tokens.delete();
      here  = next_offset;
      nxt   = (here < POS_MAX) ? here + 16'd1 : POS_MAX;
      again = !escape_pending;
      escape_pending = 1'b0;
      // a byte that ends a run without belonging to it is looked at again
      for (pass = 0; again && pass < 3; pass++) begin
         again = 1'b0;
         case (lex_mode)
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  lex_mode = MODE_LINE;
               end else if (c == CH_STAR) begin
                  lex_mode = MODE_BLOCK;
                  again = 1'b1;
               end else begin
                  close_run(KIND_TEXT, here);
                  lex_mode = MODE_NORMAL;
                  again = 1'b1;
               end
            end
            MODE_LINE, MODE_PRE: begin
               if (c == CH_NL) begin
                  close_run((lex_mode == MODE_LINE) ? KIND_LINE : KIND_PRE, nxt);
                  lex_mode = MODE_NORMAL;
               end
            end
            MODE_BLOCK: begin
               if (c == CH_STAR) lex_mode = MODE_STAR;
            end
            MODE_STAR: begin
               if (c == CH_SLASH) begin
                  close_run(KIND_BLOCK, nxt);
                  lex_mode = MODE_NORMAL;
               end else if (c != CH_STAR) begin
                  lex_mode = MODE_BLOCK;
               end
            end
            MODE_STRING, MODE_CHAR: begin
               if (c == CH_BSLASH) begin
                  escape_pending = 1'b1;
               end else if (c == ((lex_mode == MODE_STRING) ? CH_QUOTE : CH_APOS)) begin
                  close_run((lex_mode == MODE_STRING) ? KIND_STRING : KIND_CHAR, nxt);
                  lex_mode = MODE_NORMAL;
               end
            end
            MODE_NUMBER: begin
               if (!(is_word_char(c) || c == CH_DOT)) begin
                  close_run(KIND_NUMBER, here);
                  lex_mode = MODE_NORMAL;
                  again = 1'b1;
               end
            end
            default: begin
               if (c == CH_SLASH) begin
                  close_run(KIND_TEXT, here);
                  lex_mode = MODE_SLASH;
               end else if (c == CH_HASH) begin
                  close_run(KIND_TEXT, here);
                  lex_mode = MODE_PRE;
               end else if (c == CH_QUOTE) begin
                  close_run(KIND_TEXT, here);
                  lex_mode = MODE_STRING;
               end else if (c >= "0" && c <= "9") begin
                  close_run(KIND_TEXT, here);
                  lex_mode = MODE_NUMBER;
               end else if (c == CH_APOS) begin
                  close_run(KIND_TEXT, here);
                  lex_mode = MODE_CHAR;
               end
            end
         endcase
      end
      next_offset = nxt;
      // flush of the open run, then a fresh source at offset zero
      if (eos) begin
         case (lex_mode)
            MODE_LINE:             flush_kind = KIND_LINE;
            MODE_BLOCK, MODE_STAR: flush_kind = KIND_BLOCK;
            MODE_PRE:              flush_kind = KIND_PRE;
            MODE_STRING:           flush_kind = KIND_STRING;
            MODE_NUMBER:           flush_kind = KIND_NUMBER;
            MODE_CHAR:             flush_kind = KIND_CHAR;
            default:               flush_kind = KIND_TEXT;
         endcase
         emit_token(flush_kind, run_offset, nxt, 1'b1);
         lex_reset();
      end
      if (byte_tokens.size() > 0)
         byte_tokens[byte_tokens.size()-1].last_in_run = 1'b1;
   endfunction

   function automatic void add_plain(logic [7:0] b, logic eos);
      dir_row_type row;
      row.b     = b;
      row.eos   = eos;
      row.typed = 1'b0;
      row.n     = 0;
      row.tok   = '0;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_typed(logic [7:0] b, logic eos, int n, kind_type kind,
                                     logic [15:0] start, logic [15:0] len);
      dir_row_type row;
      row.b     = b;
      row.eos   = eos;
      row.typed = 1'b1;
      row.n     = n;
      row.tok   = token_type'{kind, start, len, eos, 1'b1};
      dir_rows.push_back(row);
   endfunction

   function automatic logic [7:0] text_byte();
      if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(32, 126));
   endfunction

   function automatic logic [7:0] letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return 8'h5F;
   endfunction

   // one c-like fragment appended to the source
   task automatic add_snippet();
      int r;
      int k;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         repeat ($urandom_range(1, 6)) src_q.push_back(letter());
      end else if (r < 35) begin
         k = $urandom_range(0, 3);
         src_q.push_back((k == 1) ? CH_TAB : (k == 2) ? CH_NL : CH_SPACE);
      end else if (r < 45) begin
         src_q.push_back(8'("0" + $urandom_range(0, 9)));
         repeat ($urandom_range(0, 5)) begin
            k = $urandom_range(0, 3);
            if (k == 0) src_q.push_back(8'("0" + $urandom_range(0, 9)));
            else if (k == 1) src_q.push_back(letter());
            else if (k == 2) src_q.push_back(8'("A" + $urandom_range(0, 25)));
            else src_q.push_back(CH_DOT);
         end
      end else if (r < 55) begin
         src_q.push_back(CH_QUOTE);
         repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 9) == 0) begin
               src_q.push_back(CH_BSLASH);
               src_q.push_back(8'($urandom_range(0, 255)));
            end else begin
               src_q.push_back(text_byte());
            end
         end
         src_q.push_back(CH_QUOTE);
      end else if (r < 63) begin
         src_q.push_back(CH_APOS);
         if ($urandom_range(0, 3) == 0) begin
            src_q.push_back(CH_BSLASH);
            src_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            src_q.push_back(text_byte());
         end
         src_q.push_back(CH_APOS);
      end else if (r < 70) begin
         src_q.push_back(CH_SLASH);
         src_q.push_back(CH_SLASH);
         repeat ($urandom_range(0, 10)) src_q.push_back(text_byte());
         src_q.push_back(CH_NL);
      end else if (r < 78) begin
         src_q.push_back(CH_SLASH);
         src_q.push_back(CH_STAR);
         // slash straight after the opening closes the comment
         if ($urandom_range(0, 7) == 0) begin
            src_q.push_back(CH_SLASH);
         end else begin
            repeat ($urandom_range(0, 10)) begin
               k = $urandom_range(0, 9);
               src_q.push_back((k == 0) ? CH_STAR : (k == 1) ? CH_SLASH : text_byte());
            end
            src_q.push_back(CH_STAR);
            src_q.push_back(CH_SLASH);
         end
      end else if (r < 85) begin
         src_q.push_back(CH_HASH);
         repeat ($urandom_range(0, 10)) src_q.push_back(text_byte());
         src_q.push_back(CH_NL);
      end else if (r < 95) begin
         k = $urandom_range(0, OP_COUNT - 1);
         src_q.push_back(OPERATOR_BYTES[8*k +: 8]);
      end else begin
         src_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // fragments cut to length, so the flush often lands inside an open run
   task automatic build_source(int len);
      src_q.delete();
      while (src_q.size() < len) add_snippet();
      while (src_q.size() > len) void'(src_q.pop_back());
   endtask

   // offer one byte word, predict once it is taken
   task automatic send_word(logic [7:0] b, logic eos);
      req_bus.valid         <= 1'b1;
      req_bus.source_byte   <= b;
      req_bus.end_of_source <= eos;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      lex_byte(b, eos);
      if (typed_row) begin
         foreach (typed_tokens[i]) pending_tokens.push_back(typed_tokens[i]);
      end else begin
         foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
      end
      bytes_sent++;
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_source();
      foreach (src_q[i]) send_word(src_q[i], i == src_q.size() - 1);
   endtask

   // sender waits until every expected token is out
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_sources(int total);
      int goal;
      int k;
      goal = bytes_sent + total;
      while (bytes_sent < goal) begin
         k = $urandom_range(0, 3);
         sender_idle_pct = (k == 0) ? 0 : (k == 1) ? 5 : (k == 2) ? 20 : 40;
         k = $urandom_range(0, 3);
         sink_idle_pct = (k == 0) ? 0 : (k == 1) ? 5 : (k == 2) ? 20 : 40;
         build_source(($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 60));
         send_source();
      end
   endtask

   // result side ready, with bursts of idling and the long hold-off
   initial begin
      int hold_left;
      int gap_left;
      hold_left = 0;
      gap_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_bus.ready <= 1'b0;
         end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
            gap_left = $urandom_range(0, 4);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // compare each token word with the oldest expectation
   always @(posedge clock) begin : check_tokens
      token_type got;
      token_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = token_type'{rsp_bus.token_kind, rsp_bus.token_offset, rsp_bus.token_length,
                           rsp_bus.final_token, rsp_bus.last_in_run};
         if (pending_tokens.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected token: kind %0d start %0d length %0d final %0b last %0b",
                        got.token_kind, got.token_offset, got.token_length,
                        got.final_token, got.last_in_run);
         end else begin
            want = pending_tokens.pop_front();
            if (got.token_kind !== want.token_kind || got.token_offset !== want.token_offset ||
                got.token_length !== want.token_length ||
                got.final_token !== want.final_token ||
                got.last_in_run !== want.last_in_run) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("token mismatch: expected %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                           want.token_kind, want.token_offset, want.token_length,
                           want.final_token, want.last_in_run,
                           got.token_kind, got.token_offset, got.token_length,
                           got.final_token, got.last_in_run);
            end
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("c_source_highlight_lexer_unit_tb: done, errors");
         $finish;
      end
   end

   // main sequence
   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.source_byte   <= '0;
      req_bus.end_of_source <= 1'b0;
      sender_idle_pct = 20;
      sink_idle_pct   = 20;
      hold_request    = 0;
      mismatch_count  = 0;
      bytes_sent      = 0;
      typed_row       = 1'b0;
      lex_reset();

      // single-byte sources, lone slash flush, star-seen flush
      add_typed("a", 1'b1, 1, KIND_TEXT, 16'd0, 16'd1);
      add_typed(8'hFF, 1'b1, 1, KIND_TEXT, 16'd0, 16'd1);
      add_typed(CH_SLASH, 1'b1, 1, KIND_TEXT, 16'd0, 16'd1);
      add_typed(CH_SLASH, 1'b0, 0, KIND_TEXT, 16'd0, 16'd0);
      add_typed(CH_STAR, 1'b1, 1, KIND_BLOCK, 16'd0, 16'd2);
      // comment closed by the slash right after the opening
      add_plain(CH_SLASH, 1'b0);
      add_plain(CH_STAR, 1'b0);
      add_plain(CH_SLASH, 1'b0);
      // line comment, preprocessor line
      add_plain(CH_SLASH, 1'b0);
      add_plain(CH_SLASH, 1'b0);
      add_plain(CH_NL, 1'b0);
      add_plain(CH_HASH, 1'b0);
      add_plain(CH_NL, 1'b0);
      // string and char literals with escaped quotes
      add_plain(CH_QUOTE, 1'b0);
      add_plain(CH_BSLASH, 1'b0);
      add_plain(CH_QUOTE, 1'b0);
      add_plain(CH_QUOTE, 1'b0);
      add_plain(CH_APOS, 1'b0);
      add_plain(CH_BSLASH, 1'b0);
      add_plain(CH_APOS, 1'b0);
      add_plain(CH_APOS, 1'b0);
      // number ended by a high byte, then by a slash that is looked at again
      add_plain("7", 1'b0);
      add_plain(CH_DOT, 1'b0);
      add_plain("Z", 1'b0);
      add_plain(8'h80, 1'b0);
      add_plain("0", 1'b0);
      add_plain(CH_SLASH, 1'b0);
      add_plain("q", 1'b1);
      add_plain(CH_SLASH, 1'b0);
      add_plain(CH_STAR, 1'b0);
      add_typed(CH_STAR, 1'b1, 1, KIND_BLOCK, 16'd0, 16'd3);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         typed_row = dir_rows[i].typed;
         typed_tokens.delete();
         if (typed_row && dir_rows[i].n == 1) typed_tokens.push_back(dir_rows[i].tok);
         send_word(dir_rows[i].b, dir_rows[i].eos);
      end
      typed_row = 1'b0;
      drain();

      // receiver holds off while a token-dense stream keeps coming
      sender_idle_pct = 0;
      sink_idle_pct   = 0;
      hold_request    = HOLD_CYCLES;
      src_q.delete();
      repeat (20) begin
         src_q.push_back(8'("0" + $urandom_range(0, 9)));
         src_q.push_back(CH_SLASH);
      end
      send_source();

      run_sources(800);
      drain();
      run_sources(700);

      // closing stretch with no idling
      sender_idle_pct = 0;
      sink_idle_pct   = 0;
      begin : calm_part
         int goal;
         goal = bytes_sent + 300;
         while (bytes_sent < goal) begin
            build_source($urandom_range(4, 60));
            send_source();
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_tokens.size() == 0)
         $display("c_source_highlight_lexer_unit_tb: done, clean");
      else
         $display("c_source_highlight_lexer_unit_tb: done, errors");
      $finish;
   end

endmodule
